>>> rtl/sorted_table_binary_search_defines.svh
// Assertion helpers for the checker file.
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define STBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define STBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/stbs_pkg.sv
`timescale 1ns / 1ps

package stbs_pkg;

   localparam int SIZE_W              = 11;
   localparam int ENTRY_IDX_W         = 10;
   localparam int VALUE_W             = 32;
   localparam int OUT_IDX_W           = 10;
   localparam int DEFAULT_TABLE_DEPTH = 1024;

   // request opcodes
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   typedef struct packed {
      logic                 found;
      logic [OUT_IDX_W-1:0] match_index;
   } result_type;

endpackage

>>> rtl/stbs_req_if.sv
`timescale 1ns / 1ps

interface stbs_req_if;
   import stbs_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      func;
   logic [ENTRY_IDX_W-1:0]    entry_index;
   logic signed [VALUE_W-1:0] entry_value;
   logic signed [VALUE_W-1:0] search_key;

   modport source (output valid, func, entry_index, entry_value, search_key,
                   input ready);
   modport sink (input valid, func, entry_index, entry_value, search_key,
                 output ready);
   modport monitor (input valid, ready, func, entry_index, entry_value, search_key);
endinterface

>>> rtl/stbs_rsp_if.sv
`timescale 1ns / 1ps

interface stbs_rsp_if;
   import stbs_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 found;
   logic [OUT_IDX_W-1:0] match_index;

   modport source (output valid, found, match_index, input ready);
   modport sink (input valid, found, match_index, output ready);
   modport monitor (input valid, ready, found, match_index);
endinterface

>>> rtl/stbs_table.sv
`timescale 1ns / 1ps

module stbs_table #(
   parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH,
   parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [IDX_W-1:0]                  wr_addr,
   input  logic [stbs_pkg::VALUE_W-1:0]      wr_data,
   input  logic                              rd_en,
   input  logic [IDX_W-1:0]                  rd_addr,
   output logic [stbs_pkg::VALUE_W-1:0]      rd_data
);
   import stbs_pkg::*;

   logic [VALUE_W-1:0] mem [TABLE_DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/stbs_seq.sv
`timescale 1ns / 1ps

module stbs_seq #(
   parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH,
   parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [stbs_pkg::VALUE_W-1:0]      key,
   input  logic [stbs_pkg::SIZE_W-1:0]       table_size,
   output logic                              idle,
   output logic                              rd_en,
   output logic [IDX_W-1:0]                  rd_addr,
   input  logic [stbs_pkg::VALUE_W-1:0]      rd_data,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output stbs_pkg::result_type              rsp_data
);
   import stbs_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_LOOKUP  = 4'b0010,
      ST_COMPARE = 4'b0100,
      ST_REPLY   = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;      // exclusive upper bound
   logic [IDX_W-1:0]   mid_ff, mid_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   logic               hit_ff, hit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff, rsp_data_in;

   logic [31:0]        size_wide;
   logic [CNT_W-1:0]   size_cap;
   logic [CNT_W:0]     mid_sum;
   logic [IDX_W-1:0]   mid_calc;
   logic [31:0]        mid_wide;
   logic               entry_lt, entry_gt;

   assign size_wide = 32'(table_size);
   assign size_cap  = (size_wide > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                     : CNT_W'(size_wide);

   // floor((left + right) / 2) with right = hi - 1; hi > left when used
   assign mid_sum  = (CNT_W+1)'(left_ff) + (CNT_W+1)'(hi_ff) - (CNT_W+1)'(1);
   assign mid_calc = mid_sum[IDX_W:1];
   assign mid_wide = 32'(mid_ff);

   // the shared compare unit
   assign entry_lt = $signed(rd_data) < $signed(key_ff);
   assign entry_gt = $signed(rd_data) > $signed(key_ff);

   always_comb begin
      state_in     = state_ff;
      left_in      = left_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in   = key;
               left_in  = '0;
               hi_in    = size_cap;
               hit_in   = 1'b0;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (left_ff < hi_ff) begin
               mid_in   = mid_calc;
               rd_en    = 1'b1;
               state_in = ST_COMPARE;
            end else begin
               hit_in   = 1'b0;
               state_in = ST_REPLY;
            end
         end
         ST_COMPARE: begin
            if (entry_lt) begin
               left_in  = CNT_W'(mid_ff) + CNT_W'(1);
               state_in = ST_LOOKUP;
            end else if (entry_gt) begin
               hi_in    = CNT_W'(mid_ff);
               state_in = ST_LOOKUP;
            end else begin
               hit_in   = 1'b1;
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            // output register free or being drained this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.found       = hit_ff;
               rsp_data_in.match_index = hit_ff ? mid_wide[OUT_IDX_W-1:0] : '0;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff     <= left_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      key_ff      <= key_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign idle      = (state_ff == ST_IDLE);
   assign rd_addr   = mid_calc;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/sorted_table_binary_search.sv
`timescale 1ns / 1ps
// Channel   Dir   Transfer when        Carries
// req_bus   in    valid && ready       func, entry_index, entry_value, search_key
// rsp_bus   out   valid && ready       found, match_index
// csr_*     in    csr_write_en high    table_size
//
// A write leaves the block ready. A search runs halving steps, each a registered
// table read then a compare, and ends in ST_REPLY; req_bus is not ready until it
// is back in ST_IDLE. The single read port of the table sets the step time.
// Reset clears the sequencer, the response valid and table_size; table contents
// are not cleared. A stalled response holds in its register; a following write
// is still taken, a following search finishes and then waits for it to drain.

module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   stbs_req_if.sink                       req_bus,
   stbs_rsp_if.source                     rsp_bus,
   input  logic                           csr_write_en,
   input  logic [stbs_pkg::SIZE_W-1:0]    csr_write_data
);
   import stbs_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic [SIZE_W-1:0]  table_size_ff;
   logic               req_xfer;
   logic               wr_en;
   logic               search_start;
   logic [31:0]        wr_index_wide;
   logic               seq_idle;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [VALUE_W-1:0] rd_data;
   result_type         rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= '0;
      end else if (csr_write_en) begin
         table_size_ff <= csr_write_data;
      end
   end

   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign wr_index_wide = 32'(req_bus.entry_index);
   assign wr_en         = req_xfer && (req_bus.func == FUNC_WRITE)
                          && (wr_index_wide < 32'(TABLE_DEPTH));
   assign search_start  = req_xfer && (req_bus.func == FUNC_SEARCH);
   assign req_bus.ready = seq_idle;

   stbs_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_index_wide[IDX_W-1:0]),
      .wr_data (req_bus.entry_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   stbs_seq #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (search_start),
      .key        (req_bus.search_key),
      .table_size (table_size_ff),
      .idle       (seq_idle),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_ready  (rsp_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_data   (rsp_data)
   );

   assign rsp_bus.found       = rsp_data.found;
   assign rsp_bus.match_index = rsp_data.match_index;

endmodule

>>> rtl/stbs_checker.sv
`timescale 1ns / 1ps
`include "sorted_table_binary_search_defines.svh"

module stbs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_func,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_found,
   input logic [stbs_pkg::OUT_IDX_W-1:0] rsp_match_index
);
   import stbs_pkg::*;

   logic req_xfer;
   assign req_xfer = req_valid && req_ready;

   `STBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found) && $stable(rsp_match_index), "response dropped or changed while stalled")

   `STBS_ASSERT_NOW(a_miss_index_zero, clock, reset, rsp_valid && !rsp_found, rsp_match_index == '0, "miss must report index zero")

   `STBS_ASSERT_NEXT(a_search_busy, clock, reset, req_xfer && (req_func == FUNC_SEARCH), !req_ready, "search transfer did not start the sequencer")

   `STBS_ASSERT_NEXT(a_write_ready, clock, reset, req_xfer && (req_func == FUNC_WRITE), req_ready, "write transfer left the block busy")

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_func        (req_bus.func),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_found       (rsp_bus.found),
   .rsp_match_index (rsp_bus.match_index)
);

>>> bench/binary_search_checker.sv
`timescale 1ns / 1ps

module binary_search_checker
   import stbs_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   stbs_req_if.monitor       req_mon,
   stbs_rsp_if.monitor       rsp_mon,
   input  logic              csr_write_en,
   input  logic [SIZE_W-1:0] csr_write_data,
   output int                mismatches,
   output int                lookups_in_flight
);

   logic signed [VALUE_W-1:0] entry_store [TABLE_DEPTH];
   logic [SIZE_W-1:0]         size_reg;
   result_type                pending_lookups [$];

   initial begin
      mismatches        = 0;
      lookups_in_flight = 0;
      size_reg          = '0;
   end

   // Binary search over the predicted contents, midpoint recomputed each step.
   function automatic result_type predict_lookup(logic signed [VALUE_W-1:0] key);
      result_type res;
      int         lo;
      int         hi;
      int         mid;
      bit         hit;
      lo  = 0;
      hi  = (int'(size_reg) > TABLE_DEPTH) ? TABLE_DEPTH - 1 : int'(size_reg) - 1;
      hit = 1'b0;
      res.found       = 1'b0;
      res.match_index = '0;
      while (!hit && lo <= hi) begin
         mid = (lo + hi) / 2;
         if (entry_store[mid] < key) begin
            lo = mid + 1;
         end else if (entry_store[mid] > key) begin
            hi = mid - 1;
         end else begin
            hit             = 1'b1;
            res.found       = 1'b1;
            res.match_index = mid[OUT_IDX_W-1:0];
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         pending_lookups.delete();
         size_reg = '0;
      end else begin
         // retire first: a result always belongs to an earlier search
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_lookups.size() == 0) begin
               $error("unexpected result transfer: found=%0b match_index=%0d",
                      rsp_mon.found, rsp_mon.match_index);
               mismatches++;
            end else begin
               want = pending_lookups.pop_front();
               if (rsp_mon.found !== want.found) begin
                  $error("found: expected %0b, got %0b", want.found, rsp_mon.found);
                  mismatches++;
               end
               if (rsp_mon.match_index !== want.match_index) begin
                  $error("match_index: expected %0d, got %0d",
                         want.match_index, rsp_mon.match_index);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.func == FUNC_WRITE) begin
               entry_store[req_mon.entry_index] = req_mon.entry_value;
            end else begin
               pending_lookups.push_back(predict_lookup(req_mon.search_key));
            end
         end
         if (csr_write_en) begin
            size_reg = csr_write_data;
         end
      end
      lookups_in_flight = pending_lookups.size();
   end

endmodule

>>> bench/sorted_table_binary_search_tb.sv
`timescale 1ns / 1ps

module sorted_table_binary_search_tb;
   import stbs_pkg::*;

   localparam int DEPTH          = DEFAULT_TABLE_DEPTH;
   localparam int ITEM_BUDGET    = 1250;
   localparam int LATENCY_PAD    = 32;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 3000;

   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_write_en;
   logic [SIZE_W-1:0] csr_write_data;
   int                mismatches;
   int                lookups_in_flight;

   stbs_req_if req_bus ();
   stbs_rsp_if rsp_bus ();

   sorted_table_binary_search #(.TABLE_DEPTH(DEPTH)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   binary_search_checker #(.TABLE_DEPTH(DEPTH)) search_check (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_bus),
      .rsp_mon           (rsp_bus),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .mismatches        (mismatches),
      .lookups_in_flight (lookups_in_flight)
   );

   always #2 clock = ~clock;

   // stimulus-side copy of the table, only used to pick search keys from the entries
   logic signed [VALUE_W-1:0] shadow [DEPTH];
   int span;
   int items_sent;
   bit steady_sender;
   int rsp_transfers;
   int stalled_cycles;
   bit pressure_done;

   always @(posedge clock) begin
      if (reset) begin
         rsp_transfers <= 0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         rsp_transfers <= rsp_transfers + 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
         if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Result side: random stalls, occasional steady runs, one long hold-off.
   initial begin
      int r;
      rsp_bus.ready = 1'b0;
      pressure_done = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (!pressure_done && rsp_transfers >= 20) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            pressure_done = 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
               rsp_bus.ready <= 1'b1;
               repeat ($urandom_range(50, 150)) @(negedge clock);
            end else if (r < 65) begin
               rsp_bus.ready <= 1'b1;
            end else if (r < 95) begin
               rsp_bus.ready <= 1'b0;
               repeat ($urandom_range(0, 3)) @(negedge clock);
            end else begin
               rsp_bus.ready <= 1'b0;
               repeat ($urandom_range(10, 40)) @(negedge clock);
            end
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_sender || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(logic f, logic [ENTRY_IDX_W-1:0] idx,
                            logic signed [VALUE_W-1:0] val,
                            logic signed [VALUE_W-1:0] key);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.func        <= f;
      req_bus.entry_index <= idx;
      req_bus.entry_value <= val;
      req_bus.search_key  <= key;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic write_entry(logic [ENTRY_IDX_W-1:0] idx, logic signed [VALUE_W-1:0] val);
      shadow[idx] = val;
      send_item(FUNC_WRITE, idx, val, $urandom);
   endtask

   task automatic search_for(logic signed [VALUE_W-1:0] key);
      send_item(FUNC_SEARCH, ENTRY_IDX_W'($urandom), $urandom, key);
   endtask

   // Only with the block drained and quiet for a full search time.
   task automatic set_table_size(int n);
      req_bus.valid <= 1'b0;
      wait (lookups_in_flight == 0);
      @(negedge clock);
      repeat (LATENCY_PAD) @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= n[SIZE_W-1:0];
      @(negedge clock);
      csr_write_en   <= 1'b0;
      span = (n > DEPTH) ? DEPTH : n;
   endtask

   // Ascending fill of entries 0..n-1: dense with repeats, full-range, or mid-range.
   task automatic fill_sorted(int n);
      longint v;
      longint stride;
      int     style;
      style = $urandom_range(0, 2);
      if (style == 0) begin
         v      = $signed($urandom);
         stride = 4;
      end else if (style == 1) begin
         v      = -64'sd2147483648 + $urandom_range(0, 3);
         stride = 64'hFFFF_FFFF / (n + 1) * 2;
         if (stride > 64'hFFFF_FFFF) stride = 64'hFFFF_FFFF;
      end else begin
         v      = longint'($signed($urandom)) / 2;
         stride = 65536;
      end
      for (int i = 0; i < n; i++) begin
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         write_entry(i[ENTRY_IDX_W-1:0], v[VALUE_W-1:0]);
         v += $urandom_range(0, int'(stride[31:0]));
      end
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_key();
      int r;
      logic signed [VALUE_W-1:0] k;
      r = $urandom_range(0, 99);
      if (span == 0) return (r < 50) ? $urandom : ((r < 75) ? VAL_MIN : VAL_MAX);
      k = shadow[$urandom_range(0, span - 1)];
      if (r < 55) return k;
      if (r < 80) return $urandom_range(0, 1) ? k + 1 : k - 1;
      if (r < 90) return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
      return $urandom;
   endfunction

   // Mostly searches; a few writes, some of which break the ordering.
   task automatic run_searches(int count);
      logic [ENTRY_IDX_W-1:0] idx;
      repeat (count) begin
         if ($urandom_range(0, 9) == 0) begin
            if (span > 0 && $urandom_range(0, 2) == 0) begin
               idx = ENTRY_IDX_W'($urandom_range(0, span - 1));
            end else begin
               idx = ENTRY_IDX_W'($urandom_range(0, DEPTH - 1));
            end
            write_entry(idx, $urandom);
         end else begin
            search_for(pick_key());
         end
      end
   endtask

   initial begin
      logic signed [VALUE_W-1:0] seeds [8];
      int r;
      int n;
      seeds = '{VAL_MIN, -32'sd5, -32'sd1, 32'sd0, 32'sd3, 32'sd100, VAL_MAX - 1, VAL_MAX};
      reset               = 1'b1;
      csr_write_en        = 1'b0;
      csr_write_data      = '0;
      req_bus.valid       = 1'b0;
      req_bus.func        = FUNC_WRITE;
      req_bus.entry_index = '0;
      req_bus.entry_value = '0;
      req_bus.search_key  = '0;
      items_sent          = 0;
      span                = 0;
      steady_sender       = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table
      set_table_size(0);
      search_for(32'sd0);
      search_for(VAL_MIN);

      for (int i = 0; i < 8; i++) write_entry(i[ENTRY_IDX_W-1:0], seeds[i]);
      set_table_size(8);
      search_for(VAL_MIN);
      search_for(VAL_MAX);
      search_for(32'sd0);
      search_for(-32'sd1);
      search_for(VAL_MAX - 1);
      search_for(32'sd1);
      search_for(32'sd99);

      // single entry
      set_table_size(1);
      search_for(VAL_MIN);
      search_for(32'sd0);

      // unsorted table: answer follows the search path, not membership
      write_entry(10'd3, -32'sd100);
      set_table_size(8);
      search_for(-32'sd100);
      search_for(32'sd3);

      // full table once, then sizes at and beyond the depth
      fill_sorted(DEPTH);
      set_table_size(DEPTH);
      run_searches(25);
      set_table_size((1 << SIZE_W) - 1);
      run_searches(25);
      set_table_size($urandom_range(DEPTH + 1, (1 << SIZE_W) - 2));
      run_searches(15);

      // every entry is written now, so any size is safe; small prefixes are sometimes refilled
      while (items_sent < ITEM_BUDGET) begin
         r = $urandom_range(0, 99);
         if (r < 10) n = 0;
         else if (r < 20) n = 1;
         else if (r < 85) n = $urandom_range(2, 40);
         else n = $urandom_range(41, 200);
         if (n <= 40 && $urandom_range(0, 2) == 0) fill_sorted(n);
         set_table_size(n);
         steady_sender = ($urandom_range(0, 4) == 0);
         run_searches($urandom_range(20, 60));
      end
      steady_sender = 1'b0;

      req_bus.valid <= 1'b0;
      wait (lookups_in_flight == 0);
      repeat (LATENCY_PAD) @(posedge clock);
      if (mismatches == 0 && lookups_in_flight == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
